### src/hars_pkg.sv
package hars_pkg;

  // Store geometry.
  localparam int MAX_BACKENDS = 16;
  localparam int IDX_W        = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int CNT_W        = $clog2(MAX_BACKENDS + 1);
  localparam int VIS_W        = $clog2(MAX_BACKENDS + 2);

  // Field widths.
  localparam int MODE_W   = 2;
  localparam int EIDX_W   = 4;
  localparam int SEL_W    = 4;
  localparam int ESC_W    = 2;
  localparam int HEALTH_W = 15;
  localparam int DELTA_W  = 16;
  localparam int CFG_W    = 5;
  localparam int SUM_W    = DELTA_W + 1;

  localparam logic [ESC_W-1:0] ESC_MAX = 2'd3;

  localparam logic signed [SUM_W-1:0] HEALTH_MIN = -17'sd10000;
  localparam logic signed [SUM_W-1:0] HEALTH_MAX = 17'sd10000;

  typedef enum logic [MODE_W-1:0] {
    MODE_SELECT = 2'd0,
    MODE_ADJUST = 2'd1,
    MODE_DECAY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_CMP,
    ALU_HALVE
  } alu_op_e;

  // Result of the shared arithmetic unit.
  typedef struct packed {
    logic                       in_range;
    logic                       ge;
    logic signed [HEALTH_W-1:0] value;
  } alu_res_t;

  // Write port of the score store.
  typedef struct packed {
    logic                       en;
    logic [IDX_W-1:0]           addr;
    logic signed [HEALTH_W-1:0] data;
  } store_wr_t;

  // Skip threshold after a given number of escalations.
  function automatic logic signed [HEALTH_W-1:0] thresh_at(input logic [ESC_W-1:0] esc);
    logic signed [HEALTH_W-1:0] t;
    unique case (esc)
      2'd0:    t = -15'sd10;
      2'd1:    t = -15'sd100;
      2'd2:    t = -15'sd1000;
      default: t = -15'sd10000;
    endcase
    return t;
  endfunction

endpackage

### src/hars_req_if.sv
interface hars_req_if import hars_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [EIDX_W-1:0]         entry_index;
  logic signed [DELTA_W-1:0] health_delta;

  modport source (output valid, output mode, output entry_index, output health_delta,
                  input ready);
  modport sink (input valid, input mode, input entry_index, input health_delta,
                output ready);
endinterface

### src/hars_rsp_if.sv
interface hars_rsp_if import hars_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [SEL_W-1:0]           selected_index;
  logic [ESC_W-1:0]           escalations;
  logic                       applied;
  logic signed [HEALTH_W-1:0] health_value;

  modport source (output valid, output selected_index, output escalations,
                  output applied, output health_value, input ready);
  modport sink (input valid, input selected_index, input escalations,
                input applied, input health_value, output ready);
endinterface

### src/hars_cfg_if.sv
interface hars_cfg_if import hars_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] backend_count;

  modport source (output valid, output backend_count, input ready);
  modport sink (input valid, input backend_count, output ready);
endinterface

### src/hars_store.sv
module hars_store import hars_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  store_wr_t                  wr_i,
  input  logic [IDX_W-1:0]           rd_addr_i,
  output logic signed [HEALTH_W-1:0] rd_data_o
);

  logic signed [HEALTH_W-1:0] score_q [MAX_BACKENDS];

  // Scores clear to zero at reset; at most one entry is written per cycle, when the write port is enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BACKENDS; i++) begin
        score_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      score_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = score_q[rd_addr_i];

endmodule

### src/hars_alu.sv
module hars_alu import hars_pkg::*; (
  input  alu_op_e                    op_i,
  input  logic signed [HEALTH_W-1:0] score_i,
  input  logic signed [DELTA_W-1:0]  delta_i,
  input  logic [ESC_W-1:0]           esc_i,
  output alu_res_t                   res_o
);

  logic signed [SUM_W-1:0] operand_b;
  logic                    carry_in;
  logic signed [SUM_W-1:0] sum;

  // One adder serves the adjust sum, the threshold compare and the rounding of a halving.
  always_comb begin
    unique case (op_i)
      ALU_ADD: begin
        operand_b = SUM_W'(delta_i);
        carry_in  = 1'b0;
      end
      ALU_CMP: begin
        operand_b = ~SUM_W'(thresh_at(esc_i));
        carry_in  = 1'b1;
      end
      ALU_HALVE: begin
        operand_b = '0;
        carry_in  = score_i[HEALTH_W-1];
      end
      default: begin
        operand_b = '0;
        carry_in  = 1'b0;
      end
    endcase
  end

  assign sum = SUM_W'(score_i) + operand_b + SUM_W'(carry_in);

  // A negative score gets one added before the shift, so halving truncates toward zero.
  always_comb begin
    res_o.in_range = (sum >= HEALTH_MIN) && (sum <= HEALTH_MAX);
    res_o.ge       = !sum[SUM_W-1];
    unique case (op_i)
      ALU_ADD:   res_o.value = sum[HEALTH_W-1:0];
      ALU_HALVE: res_o.value = sum[HEALTH_W:1];
      default:   res_o.value = score_i;
    endcase
  end

endmodule

### src/hars_seq.sv
module hars_seq import hars_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hars_req_if.sink                   req,
  hars_rsp_if.source                 rsp,
  input  logic [CNT_W-1:0]           eff_cnt_i,
  output store_wr_t                  store_wr_o,
  output logic [IDX_W-1:0]           rd_addr_o,
  input  logic signed [HEALTH_W-1:0] rd_data_i,
  output alu_op_e                    alu_op_o,
  output logic signed [DELTA_W-1:0]  alu_delta_o,
  output logic [ESC_W-1:0]           alu_esc_o,
  input  alu_res_t                   alu_res_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELECT,
    ST_ADJUST,
    ST_DECAY,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e                     state_q;
  logic [EIDX_W-1:0]          idx_q;
  logic signed [DELTA_W-1:0]  delta_q;
  logic [IDX_W-1:0]           ptr_q;
  logic [IDX_W-1:0]           p_q;
  logic [VIS_W-1:0]           visits_q;
  logic [ESC_W-1:0]           esc_q;
  logic [IDX_W-1:0]           sweep_q;
  logic [SEL_W-1:0]           res_sel_q;
  logic [ESC_W-1:0]           res_esc_q;
  logic                       res_app_q;
  logic signed [HEALTH_W-1:0] res_hv_q;
  logic                       out_valid_q;
  logic [SEL_W-1:0]           out_sel_q;
  logic [ESC_W-1:0]           out_esc_q;
  logic                       out_app_q;
  logic signed [HEALTH_W-1:0] out_hv_q;

  logic             req_fire;
  logic             out_free;
  logic             out_load;
  logic [IDX_W-1:0] idx_addr;
  logic             idx_ok;
  logic [CNT_W-1:0] p_inc;
  logic [IDX_W-1:0] p_next;
  logic [VIS_W-1:0] visits_inc;
  logic             escalate;
  logic [ESC_W-1:0] esc_next;
  logic [VIS_W-1:0] visits_next;
  logic             hit;
  logic             adjust_wr;

  assign req.ready = (state_q == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid_q || rsp.ready;
  assign out_load  = (state_q == ST_FINISH) && out_free;

  assign idx_addr = IDX_W'(idx_q);
  assign idx_ok   = (int'(idx_q) < MAX_BACKENDS);

  // One ring step: advance, wrap, count the visit and escalate the threshold.
  assign p_inc       = CNT_W'(p_q) + CNT_W'(1);
  assign p_next      = (p_inc >= eff_cnt_i) ? '0 : p_inc[IDX_W-1:0];
  assign visits_inc  = visits_q + VIS_W'(1);
  assign escalate    = (visits_inc > VIS_W'(eff_cnt_i));
  assign esc_next    = (escalate && (esc_q != ESC_MAX)) ? esc_q + ESC_W'(1) : esc_q;
  assign visits_next = escalate ? '0 : visits_inc;
  assign hit         = (esc_next == ESC_MAX) || alu_res_i.ge;

  assign adjust_wr = (state_q == ST_ADJUST) && idx_ok && alu_res_i.in_range;

  // Drive the store and the shared unit from the current step.
  always_comb begin
    alu_delta_o = delta_q;
    alu_esc_o   = esc_next;
    unique case (state_q)
      ST_SELECT: begin
        rd_addr_o = p_next;
        alu_op_o  = ALU_CMP;
      end
      ST_ADJUST: begin
        rd_addr_o = idx_addr;
        alu_op_o  = ALU_ADD;
      end
      ST_DECAY: begin
        rd_addr_o = sweep_q;
        alu_op_o  = ALU_HALVE;
      end
      default: begin
        rd_addr_o = idx_addr;
        alu_op_o  = ALU_CMP;
      end
    endcase
    store_wr_o.en   = adjust_wr || (state_q == ST_DECAY);
    store_wr_o.addr = (state_q == ST_DECAY) ? sweep_q : idx_addr;
    store_wr_o.data = alu_res_i.value;
  end

  // Sequencer with the result and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      delta_q     <= '0;
      ptr_q       <= '0;
      p_q         <= '0;
      visits_q    <= '0;
      esc_q       <= '0;
      sweep_q     <= '0;
      res_sel_q   <= '0;
      res_esc_q   <= '0;
      res_app_q   <= 1'b0;
      res_hv_q    <= '0;
      out_valid_q <= 1'b0;
      out_sel_q   <= '0;
      out_esc_q   <= '0;
      out_app_q   <= 1'b0;
      out_hv_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            idx_q     <= req.entry_index;
            delta_q   <= req.health_delta;
            res_sel_q <= req.entry_index;
            res_esc_q <= '0;
            res_app_q <= 1'b0;
            res_hv_q  <= '0;
            p_q       <= ptr_q;
            visits_q  <= '0;
            esc_q     <= '0;
            sweep_q   <= '0;
            unique case (mode_e'(req.mode))
              MODE_SELECT: state_q <= ST_SELECT;
              MODE_ADJUST: state_q <= ST_ADJUST;
              MODE_DECAY:  state_q <= ST_DECAY;
              MODE_NONE:   state_q <= ST_READ;
            endcase
          end
        end
        ST_SELECT: begin
          p_q      <= p_next;
          visits_q <= visits_next;
          esc_q    <= esc_next;
          if (hit) begin
            ptr_q     <= p_next;
            res_sel_q <= SEL_W'(p_next);
            res_esc_q <= esc_next;
            res_hv_q  <= rd_data_i;
            state_q   <= ST_FINISH;
          end
        end
        ST_ADJUST: begin
          if (idx_ok) begin
            res_app_q <= alu_res_i.in_range;
            res_hv_q  <= alu_res_i.in_range ? alu_res_i.value : rd_data_i;
          end
          state_q <= ST_FINISH;
        end
        ST_DECAY: begin
          sweep_q <= sweep_q + IDX_W'(1);
          if (int'(sweep_q) == MAX_BACKENDS - 1) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          res_hv_q <= idx_ok ? rd_data_i : '0;
          state_q  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_sel_q   <= res_sel_q;
            out_esc_q   <= res_esc_q;
            out_app_q   <= res_app_q;
            out_hv_q    <= res_hv_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.selected_index = out_sel_q;
  assign rsp.escalations    = out_esc_q;
  assign rsp.applied        = out_app_q;
  assign rsp.health_value   = out_hv_q;

endmodule

### src/health_aware_round_robin_select.sv
// Health-aware round-robin selector. One request is in work at a time; req_i.ready is high
// only while the sequencer is idle, and a finished result waits in the rsp_o output register
// while the next request is taken. A select probes one ring entry after another, because the
// single shared compare unit reads one score per cycle; it probes 1 to 3 * (effective count + 1)
// entries, the effective count being backend_count limited to 1..MAX_BACKENDS. An adjust is one
// read-add-write pass; a decay halves one stored score per cycle through the same unit, over all
// MAX_BACKENDS entries, and then reads the requested entry; mode 3 only reads the entry.
// The configuration channel is always ready; backend_count must only be written while idle.
module health_aware_round_robin_select import hars_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hars_cfg_if.sink    cfg_i,
  hars_req_if.sink    req_i,
  hars_rsp_if.source  rsp_o
);

  logic [CFG_W-1:0]           backend_count_q;
  logic [CNT_W-1:0]           eff_cnt;
  store_wr_t                  store_wr;
  logic [IDX_W-1:0]           rd_addr;
  logic signed [HEALTH_W-1:0] rd_data;
  alu_op_e                    alu_op;
  logic signed [DELTA_W-1:0]  alu_delta;
  logic [ESC_W-1:0]           alu_esc;
  alu_res_t                   alu_res;

  // Count register; every transfer on the configuration channel overwrites it.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backend_count_q <= CFG_W'(1);
    end else if (cfg_i.valid) begin
      backend_count_q <= cfg_i.backend_count;
    end
  end

  // A count of zero acts as one, and a count above the store depth acts as the depth.
  always_comb begin
    if (backend_count_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (int'(backend_count_q) > MAX_BACKENDS) begin
      eff_cnt = CNT_W'(MAX_BACKENDS);
    end else begin
      eff_cnt = CNT_W'(backend_count_q);
    end
  end

  hars_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .eff_cnt_i   (eff_cnt),
    .store_wr_o  (store_wr),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .alu_op_o    (alu_op),
    .alu_delta_o (alu_delta),
    .alu_esc_o   (alu_esc),
    .alu_res_i   (alu_res)
  );

  hars_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (store_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  hars_alu u_alu (
    .op_i    (alu_op),
    .score_i (rd_data),
    .delta_i (alu_delta),
    .esc_i   (alu_esc),
    .res_o   (alu_res)
  );

endmodule

### src/hars_checker.sv
module hars_checker import hars_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [ESC_W-1:0]           rsp_escalations_i,
  input logic                       rsp_applied_i,
  input logic signed [HEALTH_W-1:0] rsp_health_value_i
);

  // A result offered but not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn before its transfer");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is in work");

  // Escalations come only from a select, and only an adjust reports applied.
  a_esc_not_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_escalations_i != '0) |-> !rsp_applied_i)
    else $error("select result reports an applied adjust");

  // Stored scores never leave the allowed health range.
  a_health_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_health_value_i >= -15'sd10000) && (rsp_health_value_i <= 15'sd10000))
    else $error("health value outside the allowed range");

endmodule

bind health_aware_round_robin_select hars_checker u_hars_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_escalations_i  (rsp_o.escalations),
  .rsp_applied_i      (rsp_o.applied),
  .rsp_health_value_i (rsp_o.health_value)
);

### tb/health_aware_round_robin_select_tb.sv
`timescale 1ns / 100ps

module health_aware_round_robin_select_tb;
  import hars_pkg::*;

  // Expected content of one response transfer.
  typedef struct packed {
    logic [SEL_W-1:0]           sel;
    logic [ESC_W-1:0]           esc;
    logic                       applied;
    logic signed [HEALTH_W-1:0] hv;
  } outcome_t;

  typedef enum logic {
    ROW_WRITE_COUNT,
    ROW_REQUEST
  } row_kind_e;

  // One line of the directed table: either a backend_count write or a request.
  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_W-1:0]          count;
    mode_e                     mode;
    logic [EIDX_W-1:0]         idx;
    logic signed [DELTA_W-1:0] delta;
    logic                      typed;
    outcome_t                  want;
  } stim_row_t;

  localparam outcome_t NO_CHECK    = '0;
  localparam int       DIR_ROWS    = 27;
  localparam int       PHASES      = 14;
  localparam int       PHASE_ITEMS = 125;
  localparam int       PRINT_LIMIT = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  hars_cfg_if cfg_if ();
  hars_req_if req_if ();
  hars_rsp_if rsp_if ();

  health_aware_round_robin_select dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow state of the selector.
  logic signed [HEALTH_W-1:0] scores [MAX_BACKENDS];
  logic [IDX_W-1:0]           ring_ptr;
  logic [CFG_W-1:0]           ring_size;

  outcome_t pending_results [$];
  int       mismatch_count = 0;
  bit       steady_flow = 1'b0;
  int       rsp_stall = 0;
  int       rsp_draw;

  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_REQUEST, 5'd0, MODE_SELECT, 4'd0, 16'sd0, 1'b1, '{4'd0, 2'd0, 1'b0, 15'sd0}},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd0, 16'sd10000, 1'b1,
      '{4'd0, 2'd0, 1'b1, 15'sd10000}},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd0, 16'sd1, 1'b1, '{4'd0, 2'd0, 1'b0, 15'sd10000}},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd3, 16'h8000, 1'b1, '{4'd3, 2'd0, 1'b0, 15'sd0}},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd15, 16'sd32767, 1'b1, '{4'd15, 2'd0, 1'b0, 15'sd0}},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd15, -16'sd10000, 1'b1,
      '{4'd15, 2'd0, 1'b1, -15'sd10000}},
    '{ROW_REQUEST, 5'd0, MODE_DECAY, 4'd15, 16'sd0, 1'b1, '{4'd15, 2'd0, 1'b0, -15'sd5000}},
    '{ROW_REQUEST, 5'd0, MODE_NONE, 4'd0, -16'sd1, 1'b1, '{4'd0, 2'd0, 1'b0, 15'sd5000}},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd1, -16'sd1, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_DECAY, 4'd1, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_WRITE_COUNT, 5'd0, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_WRITE_COUNT, 5'd31, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd2, -16'sd9000, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_WRITE_COUNT, 5'd3, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd0, -16'sd3000, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd1, -16'sd200, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd0, -16'sd9500, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_ADJUST, 4'd1, -16'sd9800, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_WRITE_COUNT, 5'd17, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_NONE, 4'd15, 16'sd32767, 1'b0, NO_CHECK},
    '{ROW_WRITE_COUNT, 5'd16, MODE_SELECT, 4'd0, 16'sd0, 1'b0, NO_CHECK},
    '{ROW_REQUEST, 5'd0, MODE_SELECT, 4'd15, 16'h8000, 1'b0, NO_CHECK}
  };

  logic [CFG_W-1:0] phase_counts [10] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd2, 5'd8, 5'd16, 5'd1
  };

  // Clock.
  always #4 clk_i = ~clk_i;

  // Number of ring entries actually in use for the current backend_count.
  function automatic int lanes_in_use();
    if (ring_size == 0) return 1;
    if (ring_size > MAX_BACKENDS) return MAX_BACKENDS;
    return ring_size;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Health deltas, weighted toward amounts that push entries under the skip thresholds.
  function automatic logic signed [DELTA_W-1:0] pick_delta();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return DELTA_W'($urandom_range(0, 100) - 60);
    if (roll < 65) return DELTA_W'(-$urandom_range(1000, 12000));
    if (roll < 85) return DELTA_W'($urandom_range(0, 24000) - 12000);
    return DELTA_W'($urandom);
  endfunction

  // Applies one request to the shadow state and returns the response it must produce.
  function automatic outcome_t compute_outcome(input mode_e m, input logic [EIDX_W-1:0] idx,
                                               input logic signed [DELTA_W-1:0] delta);
    outcome_t r;
    int       lanes;
    int       visits;
    int       p;
    int       thresh;
    int       sum;
    bit       found;
    r = '0;
    r.sel = idx;
    case (m)
      MODE_SELECT: begin
        // Walk the ring; after each full lap plus one the threshold gets ten times lower.
        lanes = lanes_in_use();
        thresh = -10;
        visits = 0;
        p = ring_ptr;
        found = 1'b0;
        while (!found) begin
          p = p + 1;
          if (p >= lanes) p = 0;
          visits++;
          if (visits > lanes) begin
            if (r.esc < ESC_MAX) begin
              r.esc = r.esc + 1'b1;
              thresh = thresh * 10;
            end
            visits = 0;
          end
          found = (r.esc == ESC_MAX) || (int'(scores[p]) >= thresh);
        end
        ring_ptr = IDX_W'(p);
        r.sel = SEL_W'(p);
        r.hv = scores[p];
      end
      MODE_ADJUST: begin
        sum = int'(scores[idx]) + int'(delta);
        if (sum >= HEALTH_MIN && sum <= HEALTH_MAX) begin
          scores[idx] = HEALTH_W'(sum);
          r.applied = 1'b1;
        end
        r.hv = scores[idx];
      end
      MODE_DECAY: begin
        // Every entry is halved, toward zero, whether in use or not.
        for (int i = 0; i < MAX_BACKENDS; i++) scores[i] = HEALTH_W'(int'(scores[i]) / 2);
        r.hv = scores[idx];
      end
      default: begin
        r.hv = scores[idx];
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  // Presents one request and records its expected response on the accepting edge.
  task automatic send_request(input mode_e m, input logic [EIDX_W-1:0] idx,
                              input logic signed [DELTA_W-1:0] delta);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= m;
    req_if.entry_index <= idx;
    req_if.health_delta <= delta;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(compute_outcome(m, idx, delta));
  endtask

  // Writes backend_count once the block has drained.
  task automatic write_count(input logic [CFG_W-1:0] value);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.backend_count <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    ring_size = value;
  endtask

  // Response side: random stalls, with none while steady flow is on.
  always @(posedge clk_i) begin
    if (steady_flow) begin
      rsp_stall <= 0;
      rsp_if.ready <= 1'b1;
    end else if (rsp_stall != 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_draw = pick_gap();
      rsp_stall <= (rsp_draw > 0) ? rsp_draw - 1 : 0;
      rsp_if.ready <= (rsp_draw == 0);
    end
  end

  // Compare each response transfer with the oldest expectation.
  always @(posedge clk_i) begin : rsp_check
    outcome_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response transfer with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.selected_index !== want.sel)
          report_mismatch($sformatf("selected_index %0d, expected %0d",
                                    rsp_if.selected_index, want.sel));
        if (rsp_if.escalations !== want.esc)
          report_mismatch($sformatf("escalations %0d, expected %0d",
                                    rsp_if.escalations, want.esc));
        if (rsp_if.applied !== want.applied)
          report_mismatch($sformatf("applied %0b, expected %0b", rsp_if.applied, want.applied));
        if (rsp_if.health_value !== want.hv)
          report_mismatch($sformatf("health_value %0d, expected %0d",
                                    rsp_if.health_value, want.hv));
      end
    end
  end

  // Main sequence: reset, directed table, randomized phases, drain.
  initial begin
    stim_row_t        row;
    logic [CFG_W-1:0] count_val;
    logic [EIDX_W-1:0] pick_idx;
    int               lanes;
    int               roll;
    int               drain;
    rst_ni = 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.backend_count <= 5'd1;
    req_if.valid <= 1'b0;
    req_if.mode <= MODE_SELECT;
    req_if.entry_index <= '0;
    req_if.health_delta <= '0;
    for (int i = 0; i < MAX_BACKENDS; i++) scores[i] = '0;
    ring_ptr = '0;
    ring_size = 5'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; rows marked typed replace the predicted response.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_table[i];
      if (row.kind == ROW_WRITE_COUNT) begin
        write_count(row.count);
      end else begin
        send_request(row.mode, row.idx, row.delta);
        if (row.typed) pending_results[pending_results.size() - 1] = row.want;
      end
    end

    // Randomized phases, each under its own backend_count.
    for (int ph = 0; ph < PHASES; ph++) begin
      count_val = (ph < 10) ? phase_counts[ph] : CFG_W'($urandom_range(0, 31));
      write_count(count_val);
      steady_flow = ($urandom_range(0, 3) == 0);
      lanes = lanes_in_use();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          send_request(MODE_SELECT, EIDX_W'($urandom), DELTA_W'($urandom));
        end else if (roll < 80) begin
          pick_idx = ($urandom_range(0, 4) != 0) ? EIDX_W'($urandom_range(0, lanes - 1))
                                                : EIDX_W'($urandom);
          send_request(MODE_ADJUST, pick_idx, pick_delta());
        end else if (roll < 92) begin
          send_request(MODE_DECAY, EIDX_W'($urandom), DELTA_W'($urandom));
        end else begin
          send_request(MODE_NONE, EIDX_W'($urandom), DELTA_W'($urandom));
        end
      end
    end

    // Drain outstanding responses, then allow the longest select to settle.
    req_if.valid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (64) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
